// ----- rtl/core/sakv_pkg.sv -----
`timescale 1ns / 1ps
package sakv_pkg;
   localparam int SETS_DEF = 1024;
   localparam int WAYS_DEF = 8;
   localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   localparam logic CSR_NUM_SETS = 1'b0;
   localparam logic CSR_NUM_WAYS = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [31:0]        lookup_key;
      logic signed [31:0] store_value;
      logic [31:0]        clock_stamp;
   } req_type;

   typedef struct packed {
      logic               valid;
      logic [31:0]        key;
      logic signed [31:0] value;
      logic [31:0]        stamp;
   } entry_type;
endpackage

// ----- rtl/core/sakv_front.sv -----
`timescale 1ns / 1ps
// accepts requests, computes key % sets one bit a cycle
module sakv_front #(
   parameter int SETS = sakv_pkg::SETS_DEF,
   localparam int SW = $clog2(SETS + 1),
   localparam int IW = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sakv_pkg::req_type req_in,
   input  logic [SW-1:0]     sets_eff,
   output logic              q_valid,
   input  logic              q_ready,
   output sakv_pkg::req_type q_req,
   output logic [IW-1:0]     q_set
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type        state_ff, state_in;
   sakv_pkg::req_type req_ff;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [SW:0]       shifted;

   assign shifted   = {rem_ff, req_ff.lookup_key[cnt_ff]};
   assign req_ready = (state_ff == F_IDLE);
   assign q_valid   = (state_ff == F_PUSH);
   assign q_req     = req_ff;
   assign q_set     = IW'(rem_ff);

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_DIV;
               rem_in   = '0;
               cnt_in   = 5'd31;
            end
         end
         F_DIV: begin
            if (shifted >= {1'b0, sets_eff}) begin
               rem_in = SW'(shifted - {1'b0, sets_eff});
            end else begin
               rem_in = SW'(shifted);
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (q_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end
endmodule

// ----- rtl/core/sakv_queue.sv -----
`timescale 1ns / 1ps
// two-entry request queue
module sakv_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] slot_ff [2];
   logic [1:0]   count_ff;
   logic         wr_ff, rd_ff;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end
endmodule

// ----- rtl/core/sakv_back.sv -----
`timescale 1ns / 1ps
// clear after reset, way scan over the entry memory, write-back and response register
module sakv_back #(
   parameter int SETS = sakv_pkg::SETS_DEF,
   parameter int WAYS = sakv_pkg::WAYS_DEF,
   localparam int DEPTH = SETS * WAYS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int IW = (SETS > 1) ? $clog2(SETS) : 1,
   localparam int WW = $clog2(WAYS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  sakv_pkg::req_type  q_req,
   input  logic [IW-1:0]      q_set,
   input  logic [WW-1:0]      ways_eff,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value
);
   typedef enum logic [4:0] {
      B_CLEAR = 5'b00001,
      B_IDLE  = 5'b00010,
      B_ISSUE = 5'b00100,
      B_EVAL  = 5'b01000,
      B_WRITE = 5'b10000
   } bstate_type;

   sakv_pkg::entry_type mem_ff [DEPTH];
   sakv_pkg::entry_type rd_data_ff, wr_data;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_en;

   bstate_type          state_ff, state_in;
   sakv_pkg::req_type   req_ff;
   logic [AW-1:0]       base_ff, clr_ff;
   logic [WW-1:0]       way_ff, match_way_ff, free_way_ff, evict_way_ff, pick_way;
   logic                match_ff, free_ff;
   logic [31:0]         oldest_ff;
   logic signed [31:0]  match_val_ff;
   logic                rsp_valid_ff, rsp_hit_ff;
   logic signed [31:0]  rsp_val_ff;
   logic                out_free, last_way;

   assign q_ready        = (state_ff == B_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign last_way       = (way_ff == ways_eff - WW'(1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rd_addr        = AW'({1'b0, base_ff} + (AW + 1)'(way_ff));

   always_comb begin
      if (match_ff) pick_way = match_way_ff;
      else if (free_ff) pick_way = free_way_ff;
      else pick_way = evict_way_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'({1'b0, base_ff} + (AW + 1)'(pick_way));
      wr_data = '{valid: 1'b1, key: req_ff.lookup_key,
                  value: (req_ff.opcode == sakv_pkg::OP_SET) ? req_ff.store_value
                                                             : match_val_ff,
                  stamp: req_ff.clock_stamp};
      if (state_ff == B_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == B_WRITE && out_free) begin
         wr_en = (req_ff.opcode == sakv_pkg::OP_SET) || match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = B_IDLE;
         B_IDLE:  if (q_valid) state_in = B_ISSUE;
         B_ISSUE: state_in = B_EVAL;
         B_EVAL: begin
            if ((rd_data_ff.valid && rd_data_ff.key == req_ff.lookup_key) || last_way) begin
               state_in = B_WRITE;
            end else begin
               state_in = B_ISSUE;
            end
         end
         B_WRITE: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == B_WRITE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      case (state_ff)
         B_IDLE: begin
            req_ff    <= q_req;
            base_ff   <= AW'(q_set) * AW'(ways_eff);
            way_ff    <= '0;
            match_ff  <= 1'b0;
            free_ff   <= 1'b0;
            oldest_ff <= sakv_pkg::STAMP_MAX;
            evict_way_ff <= '0;
            free_way_ff  <= '0;
            match_way_ff <= '0;
         end
         B_EVAL: begin
            if (!rd_data_ff.valid) begin
               if (!free_ff) begin
                  free_ff     <= 1'b1;
                  free_way_ff <= way_ff;
               end
            end else if (rd_data_ff.key == req_ff.lookup_key) begin
               match_ff     <= 1'b1;
               match_way_ff <= way_ff;
               match_val_ff <= rd_data_ff.value;
            end else if (rd_data_ff.stamp < oldest_ff) begin
               oldest_ff    <= rd_data_ff.stamp;
               evict_way_ff <= way_ff;
            end
            way_ff <= way_ff + WW'(1);
         end
         B_WRITE: begin
            if (out_free) begin
               rsp_hit_ff <= match_ff;
               rsp_val_ff <= (req_ff.opcode == sakv_pkg::OP_GET && match_ff) ? match_val_ff
                                                                            : 32'sd0;
            end
         end
         default: ;
      endcase
   end

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CLEAR |-> !(q_valid && q_ready)) else $error("pop during clear");
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == B_CLEAR || state_ff == B_WRITE)) else $error("stray write");
   a_way_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_EVAL |-> way_ff < ways_eff) else $error("way out of range");
   a_write_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_WRITE && out_free |=> rsp_valid_ff && state_ff == B_IDLE)
      else $error("response lost");
endmodule

// ----- rtl/core/set_assoc_kv_cache_lru.sv -----
`timescale 1ns / 1ps
// The front computes key % sets, one bit per cycle; the back then scans the ways of
// the set, one read of the entry memory per way, until the key matches or the last way.
// The front takes no new request until it has pushed the last one into the queue; the
// queue overlaps the back scan of one request with the divide of the next.
// Reset: synchronous; after reset the back clears the valid bits of all SETS * WAYS
// entries, one per cycle, before it takes the first request. Config resets to 1024 / 8.
module set_assoc_kv_cache_lru #(
   parameter int SETS = sakv_pkg::SETS_DEF,
   parameter int WAYS = sakv_pkg::WAYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [31:0]        req_lookup_key,
   input  logic signed [31:0] req_store_value,
   input  logic [31:0]        req_clock_stamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [10:0]        csr_wdata
);
   localparam int SW = $clog2(SETS + 1);
   localparam int IW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW = $clog2(WAYS + 1);
   localparam int QW = $bits(sakv_pkg::req_type) + IW;

   logic [10:0]       num_sets_ff;
   logic [3:0]        num_ways_ff;
   logic [SW-1:0]     sets_eff;
   logic [WW-1:0]     ways_eff;
   sakv_pkg::req_type req_in, fq_req, qb_req;
   logic [IW-1:0]     fq_set, qb_set;
   logic              fq_valid, fq_ready, qb_valid, qb_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_sets_ff <= 11'd1024;
         num_ways_ff <= 4'd8;
      end else if (csr_we) begin
         case (csr_index)
            sakv_pkg::CSR_NUM_SETS: num_sets_ff <= csr_wdata;
            sakv_pkg::CSR_NUM_WAYS: num_ways_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_sets_ff == 11'd0) sets_eff = SW'(1);
      else if (32'(num_sets_ff) > 32'(SETS)) sets_eff = SW'(SETS);
      else sets_eff = SW'(num_sets_ff);
      if (num_ways_ff == 4'd0) ways_eff = WW'(1);
      else if (32'(num_ways_ff) > 32'(WAYS)) ways_eff = WW'(WAYS);
      else ways_eff = WW'(num_ways_ff);
   end

   assign req_in = '{opcode: req_opcode, lookup_key: req_lookup_key,
                     store_value: req_store_value, clock_stamp: req_clock_stamp};

   sakv_front #(.SETS(SETS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_in, .sets_eff,
      .q_valid(fq_valid), .q_ready(fq_ready), .q_req(fq_req), .q_set(fq_set)
   );

   sakv_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data({fq_req, fq_set}),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data({qb_req, qb_set})
   );

   sakv_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
      .clock, .reset, .q_valid(qb_valid), .q_ready(qb_ready), .q_req(qb_req),
      .q_set(qb_set), .ways_eff, .rsp_valid, .rsp_ready, .rsp_hit, .rsp_read_value
   );
endmodule
